### rtl/core/u8plw_pkg.sv
`default_nettype none

package u8plw_pkg;

  localparam int OFS_W          = 14;
  localparam int PEN_W          = 11;
  localparam int GLYPH_W        = 7;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 11;

  localparam int MAX_TEXT_BYTES = 8192;
  localparam int OFFSET_CAP_INT = (MAX_TEXT_BYTES < 16383) ? MAX_TEXT_BYTES : 16383;
  localparam logic [OFS_W-1:0] OFFSET_CAP = OFS_W'(OFFSET_CAP_INT);

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NARROW_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_WIDTH    = 2'd2;

  localparam logic [PEN_W-1:0]   DISPLAY_WIDTH_RST = 11'd128;
  localparam logic [GLYPH_W-1:0] NARROW_WIDTH_RST  = 7'd8;
  localparam logic [GLYPH_W-1:0] WIDE_WIDTH_RST    = 7'd16;
  localparam logic [PEN_W-1:0]   PEN_MAX           = 11'h7FF;

  localparam logic [1:0] CAUSE_NEWLINE = 2'd0;
  localparam logic [1:0] CAUSE_WIDTH   = 2'd1;
  localparam logic [1:0] CAUSE_END     = 2'd2;

  localparam logic [7:0] BYTE_NEWLINE  = 8'h0A;
  localparam logic [7:0] BYTE_QUESTION = 8'h3F;

  typedef struct packed {
    logic [OFS_W-1:0] line_head;
    logic [OFS_W-1:0] line_end;
    logic [1:0]       break_cause;
    logic             final_line;
    logic             too_long;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } push_t;

  typedef struct packed {
    logic has_room;
    logic not_empty;
  } qstat_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (b < 8'h80) begin
      len = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  function automatic logic [20:0] code_point(input logic [31:0] bytes);
    logic [7:0]  b0;
    logic [5:0]  c1;
    logic [5:0]  c2;
    logic [5:0]  c3;
    logic [20:0] cp;
    b0 = bytes[31:24];
    c1 = bytes[21:16];
    c2 = bytes[13:8];
    c3 = bytes[5:0];
    if (b0 < 8'h80) begin
      cp = {13'd0, b0};
    end else if ((b0 & 8'hE0) == 8'hC0) begin
      cp = {10'd0, b0[4:0], c1};
    end else if ((b0 & 8'hF0) == 8'hE0) begin
      cp = {5'd0, b0[3:0], c1, c2};
    end else if ((b0 & 8'hF8) == 8'hF0) begin
      cp = {b0[2:0], c1, c2, c3};
    end else begin
      cp = {13'd0, BYTE_QUESTION};
    end
    return cp;
  endfunction

endpackage

`default_nettype wire

### rtl/core/u8plw_in_if.sv
`default_nettype none

interface u8plw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       has_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output has_byte, output end_of_text,
                  input ready);
  modport sink (input valid, input text_byte, input has_byte, input end_of_text,
                output ready);
endinterface

`default_nettype wire

### rtl/core/u8plw_out_if.sv
`default_nettype none

interface u8plw_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] line_head;
  logic [13:0] line_end;
  logic [1:0]  break_cause;
  logic        final_line;
  logic        too_long;

  modport source (output valid, output line_head, output line_end, output break_cause,
                  output final_line, output too_long, input ready);
  modport sink (input valid, input line_head, input line_end, input break_cause,
                input final_line, input too_long, output ready);
endinterface

`default_nettype wire

### rtl/core/utf8_pixel_line_wrapper_unit.sv
// UTF-8 pixel line wrapper. Text bytes arrive on in_ch, a byte and/or an end
// marker per item, and line ranges leave on out_ch as start and end byte
// offsets with the break cause, a final-line flag and a saturation flag.
// The configuration port takes display_width, narrow_glyph_width and
// wide_glyph_width at indexes 0, 1 and 2; write it only while the block is
// idle. An input item is decoded and wrapped in the cycle it is accepted,
// and its line ranges enter a four-entry result queue at that edge.
// A result passes from the queue through the output register to out_ch.
// The block takes one item per cycle as long as the queue has room for two
// results; an item that yields two lines sends both in turn on out_ch.
// When the receiver stalls, results collect in the output register and the
// queue, and in_ch.ready falls once fewer than two entries are free.
// Synchronous reset restores the register defaults, clears the text state
// and empties the queue; no result is lost at a stall.
`default_nettype none

module utf8_pixel_line_wrapper_unit
  import u8plw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  u8plw_in_if.sink                   in_ch,
  u8plw_out_if.source                out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  push_t  push;
  qstat_t qstat;
  res_t   head;
  res_t   out_res;
  logic   pop;

  u8plw_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_text_byte   (in_ch.text_byte),
    .in_has_byte    (in_ch.has_byte),
    .in_end_of_text (in_ch.end_of_text),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .qstat          (qstat),
    .push           (push)
  );

  u8plw_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  u8plw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.line_head   = out_res.line_head;
  assign out_ch.line_end    = out_res.line_end;
  assign out_ch.break_cause = out_res.break_cause;
  assign out_ch.final_line  = out_res.final_line;
  assign out_ch.too_long    = out_res.too_long;

endmodule

`default_nettype wire

### rtl/core/u8plw_front.sv
`default_nettype none

module u8plw_front
  import u8plw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_text_byte,
  input  wire logic                  in_has_byte,
  input  wire logic                  in_end_of_text,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire qstat_t                qstat,
  output push_t                      push
);

  logic [PEN_W-1:0]   disp_w_r;
  logic [GLYPH_W-1:0] narrow_w_r;
  logic [GLYPH_W-1:0] wide_w_r;

  logic [OFS_W-1:0] byte_pos_r, byte_pos_nxt;
  logic [OFS_W-1:0] line_head_r, line_head_nxt;
  logic [PEN_W-1:0] pen_r, pen_nxt;
  logic [31:0]      chb_r, chb_nxt;
  logic [1:0]       pend_r, pend_nxt;
  logic [OFS_W-1:0] cs_r, cs_nxt;
  logic             ovf_r, ovf_nxt;

  logic             accept;
  logic             fin;
  logic [2:0]       len;
  logic [1:0]       idx;
  logic [20:0]      cp;
  logic [GLYPH_W-1:0] glyph_w;
  logic [PEN_W:0]   sum;
  logic [PEN_W:0]   sum2;
  logic [PEN_W-1:0] pen_base;
  logic             brk_v;
  logic             eot_v;
  res_t             brk;
  res_t             eot_res;

  assign in_ready = qstat.has_room;
  assign accept   = in_valid && qstat.has_room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_w_r   <= DISPLAY_WIDTH_RST;
      narrow_w_r <= NARROW_WIDTH_RST;
      wide_w_r   <= WIDE_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DISPLAY_WIDTH: disp_w_r   <= cfg_data;
        CFG_NARROW_WIDTH:  narrow_w_r <= cfg_data[GLYPH_W-1:0];
        CFG_WIDE_WIDTH:    wide_w_r   <= cfg_data[GLYPH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r  <= '0;
      line_head_r <= '0;
      pen_r       <= '0;
      chb_r       <= '0;
      pend_r      <= '0;
      cs_r        <= '0;
      ovf_r       <= 1'b0;
    end else begin
      byte_pos_r  <= byte_pos_nxt;
      line_head_r <= line_head_nxt;
      pen_r       <= pen_nxt;
      chb_r       <= chb_nxt;
      pend_r      <= pend_nxt;
      cs_r        <= cs_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  always_comb begin
    byte_pos_nxt   = byte_pos_r;
    line_head_nxt  = line_head_r;
    pen_nxt        = pen_r;
    chb_nxt        = chb_r;
    pend_nxt       = pend_r;
    cs_nxt         = cs_r;
    ovf_nxt        = ovf_r;
    fin            = 1'b0;
    brk_v          = 1'b0;
    eot_v          = 1'b0;
    brk            = '0;
    eot_res        = '0;
    len            = lead_len(in_text_byte);
    idx            = 2'(lead_len(chb_r[31:24]) - {1'b0, pend_r});

    if (accept && in_has_byte) begin
      if (byte_pos_r < OFFSET_CAP) begin
        byte_pos_nxt = byte_pos_r + 1'b1;
      end else begin
        byte_pos_nxt = OFFSET_CAP;
        ovf_nxt      = 1'b1;
      end
      if (pend_r == 2'd0) begin
        if (in_text_byte == BYTE_NEWLINE) begin
          brk_v            = 1'b1;
          brk.line_head    = line_head_r;
          brk.line_end     = byte_pos_r;
          brk.break_cause  = CAUSE_NEWLINE;
          line_head_nxt    = byte_pos_nxt;
          pen_nxt          = '0;
        end else begin
          chb_nxt = {in_text_byte, 24'd0};
          cs_nxt  = byte_pos_r;
          if (len == 3'd1) begin
            fin = 1'b1;
          end else begin
            pend_nxt = 2'(len - 3'd1);
          end
        end
      end else begin
        case (idx)
          2'd1:    chb_nxt[23:16] = in_text_byte;
          2'd2:    chb_nxt[15:8]  = in_text_byte;
          2'd3:    chb_nxt[7:0]   = in_text_byte;
          default: ;
        endcase
        pend_nxt = pend_r - 2'd1;
        if (pend_r == 2'd1) begin
          fin = 1'b1;
        end
      end
    end

    cp       = code_point(chb_nxt);
    glyph_w  = (cp < 21'h80) ? narrow_w_r : wide_w_r;
    sum      = {1'b0, pen_r} + {{(PEN_W+1-GLYPH_W){1'b0}}, glyph_w};
    pen_base = pen_r;
    if (fin) begin
      if (sum > {1'b0, disp_w_r} && cs_nxt != line_head_r) begin
        brk_v           = 1'b1;
        brk.line_head   = line_head_r;
        brk.line_end    = cs_nxt;
        brk.break_cause = CAUSE_WIDTH;
        line_head_nxt   = cs_nxt;
        pen_base        = '0;
      end
    end
    sum2 = {1'b0, pen_base} + {{(PEN_W+1-GLYPH_W){1'b0}}, glyph_w};
    if (fin) begin
      pen_nxt  = sum2[PEN_W] ? PEN_MAX : sum2[PEN_W-1:0];
      pend_nxt = 2'd0;
    end
    brk.final_line = 1'b0;
    brk.too_long   = ovf_nxt;

    if (accept && in_end_of_text) begin
      eot_v               = 1'b1;
      eot_res.line_head   = line_head_nxt;
      eot_res.line_end    = byte_pos_nxt;
      eot_res.break_cause = CAUSE_END;
      eot_res.final_line  = 1'b1;
      eot_res.too_long    = ovf_nxt;
      byte_pos_nxt        = '0;
      line_head_nxt       = '0;
      pen_nxt             = '0;
      chb_nxt             = '0;
      pend_nxt            = '0;
      cs_nxt              = '0;
      ovf_nxt             = 1'b0;
    end
  end

  always_comb begin
    push.cnt    = {1'b0, brk_v} + {1'b0, eot_v};
    push.first  = brk_v ? brk : eot_res;
    push.second = eot_res;
  end

endmodule

`default_nettype wire

### rtl/core/u8plw_queue.sv
`default_nettype none

module u8plw_queue
  import u8plw_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  input  wire logic  pop,
  output res_t       head,
  output qstat_t     qstat
);

  res_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [QPTR_W-1:0] wr_ptr_p1;

  assign wr_ptr_p1       = wr_ptr_r + 1'b1;
  assign head            = mem_r[rd_ptr_r];
  assign qstat.not_empty = (cnt_r != '0);
  assign qstat.has_room  = (cnt_r <= QCNT_W'(QDEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push.cnt) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/u8plw_back.sv
`default_nettype none

module u8plw_back
  import u8plw_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire qstat_t qstat,
  input  wire res_t   head,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_ready,
  output res_t        out_res
);

  logic valid_r, valid_nxt;
  res_t res_r;

  assign pop       = qstat.not_empty && (!valid_r || out_ready);
  assign valid_nxt = pop || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= head;
    end
  end

endmodule

`default_nettype wire

### dv/tb_top.sv
`default_nettype none

module tb_top;
  import u8plw_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  u8plw_in_if in_ch();
  u8plw_out_if out_ch();

  utf8_pixel_line_wrapper_unit i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  int errors = 0;
  int reported = 0;
  int cycles = 0;
  int idle_pct = 0;
  int hold_left = 0;
  res_t expected_lines[$];
  res_t want_line;
  res_t got_line;

  // Line-wrapper state as the block should hold it.
  int disp_w;
  int narrow_w;
  int wide_w;
  int byte_pos;
  int line_begin;
  int pen;
  logic [31:0] glyph_seq;
  int cont_left;
  int glyph_begin;
  logic saturated;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.text_byte = 8'h00;
    in_ch.has_byte = 1'b0;
    in_ch.end_of_text = 1'b0;
    out_ch.ready = 1'b0;
  end

  function automatic int seq_len(input logic [7:0] lead);
    casez (lead)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default: return 1;
    endcase
  endfunction

  function automatic int unicode_of(input logic [31:0] seq);
    logic [7:0] lead;
    lead = seq[31:24];
    casez (lead)
      8'b0???????: return int'(lead);
      8'b110?????: return int'({lead[4:0], seq[21:16]});
      8'b1110????: return int'({lead[3:0], seq[21:16], seq[13:8]});
      8'b11110???: return int'({lead[2:0], seq[21:16], seq[13:8], seq[5:0]});
      default: return int'(BYTE_QUESTION);
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    int r;
    r = $urandom_range(99);
    if (r < 2) begin
      return BYTE_NEWLINE;
    end else if (r < 12) begin
      return 8'($urandom_range(255));
    end
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  task automatic add_line(input int s, input int e, input logic [1:0] cause, input logic fin);
    res_t r;
    r.line_head = OFS_W'(s);
    r.line_end = OFS_W'(e);
    r.break_cause = cause;
    r.final_line = fin;
    r.too_long = saturated;
    expected_lines.push_back(r);
  endtask

  task automatic clear_text();
    byte_pos = 0;
    line_begin = 0;
    pen = 0;
    glyph_seq = '0;
    cont_left = 0;
    glyph_begin = 0;
    saturated = 1'b0;
  endtask

  task automatic place_glyph();
    int w;
    int nx;
    w = (unicode_of(glyph_seq) < 'h80) ? narrow_w : wide_w;
    if (pen + w > disp_w && glyph_begin != line_begin) begin
      add_line(line_begin, glyph_begin, CAUSE_WIDTH, 1'b0);
      line_begin = glyph_begin;
      pen = 0;
    end
    nx = pen + w;
    pen = (nx > int'(PEN_MAX)) ? int'(PEN_MAX) : nx;
    cont_left = 0;
  endtask

  task automatic wrap_byte(input logic [7:0] b, input logic has, input logic eot);
    int pos;
    int next;
    int len;
    int slot;
    if (has) begin
      pos = byte_pos;
      if (pos < int'(OFFSET_CAP)) begin
        next = pos + 1;
      end else begin
        next = int'(OFFSET_CAP);
        saturated = 1'b1;
      end
      if (cont_left == 0) begin
        if (b == BYTE_NEWLINE) begin
          add_line(line_begin, pos, CAUSE_NEWLINE, 1'b0);
          line_begin = next;
          pen = 0;
        end else begin
          len = seq_len(b);
          glyph_seq = {b, 24'h000000};
          glyph_begin = pos;
          if (len == 1) begin
            place_glyph();
          end else begin
            cont_left = len - 1;
          end
        end
      end else begin
        len = seq_len(glyph_seq[31:24]);
        slot = (len - cont_left) & 3;
        glyph_seq = glyph_seq | (32'(b) << (24 - 8 * slot));
        cont_left--;
        if (cont_left == 0) begin
          place_glyph();
        end
      end
      byte_pos = next;
    end
    if (eot) begin
      add_line(line_begin, byte_pos, CAUSE_END, 1'b1);
      clear_text();
    end
  endtask

  task automatic send_item(input logic [7:0] b, input logic has, input logic eot);
    int gap;
    @(negedge clk);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.text_byte = b;
    in_ch.has_byte = has;
    in_ch.end_of_text = eot;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    wrap_byte(b, has, eot);
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_lines.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_DISPLAY_WIDTH: disp_w = value & 'h7FF;
      CFG_NARROW_WIDTH: narrow_w = value & 'h7F;
      CFG_WIDE_WIDTH: wide_w = value & 'h7F;
      default: ;
    endcase
  endtask

  task automatic set_widths(input int dw, input int nw, input int ww);
    write_reg(CFG_DISPLAY_WIDTH, dw);
    write_reg(CFG_NARROW_WIDTH, nw);
    write_reg(CFG_WIDE_WIDTH, ww);
  endtask

  task automatic send_text(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_item(bytes[i], 1'b1, 1'b0);
  endtask

  task automatic test_empty_text();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'hAA, 1'b0, 1'b1);
    settle();
  endtask

  task automatic test_utf8_decoding();
    send_text('{8'h00, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                8'hF0, 8'h9F, 8'h98, 8'h80, 8'hFF, 8'h80, 8'hC3, BYTE_NEWLINE,
                BYTE_NEWLINE});
    send_item(8'h41, 1'b1, 1'b1);
    settle();
  endtask

  task automatic test_wrap_rules();
    set_widths(16, 64, 1);
    send_text('{8'h41, 8'h42, 8'hC3, 8'hA9, 8'hE2, 8'h82});
    send_item(8'h00, 1'b0, 1'b1);
    settle();
  endtask

  // The text runs past the offset range, then piles wide characters on the
  // saturated position until the pen clamps.
  task automatic test_offset_saturation();
    idle_pct = 0;
    set_widths(1024, 1, 64);
    for (int i = 0; i < int'(OFFSET_CAP) + 20; i++) begin
      send_item(8'($urandom_range('h21, 'h7E)), 1'b1, 1'b0);
    end
    for (int i = 0; i < 48; i++) begin
      send_item(8'hC0 | 8'($urandom_range(2, 31)), 1'b1, 1'b0);
      send_item(8'h80 | 8'($urandom_range(63)), 1'b1, 1'b0);
    end
    send_item(BYTE_NEWLINE, 1'b1, 1'b0);
    send_item(8'h7A, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    settle();
  endtask

  task automatic random_text(input int count);
    int sent;
    int kind;
    int len;
    int cut;
    logic [7:0] lead;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        send_item(8'($urandom_range('h20, 'h7E)), 1'b1, 1'b0);
        sent++;
      end else if (kind < 65) begin
        len = $urandom_range(2, 4);
        lead = (len == 2) ? (8'hC0 | 8'($urandom_range(31))) :
               (len == 3) ? (8'hE0 | 8'($urandom_range(15))) :
                            (8'hF0 | 8'($urandom_range(7)));
        send_item(lead, 1'b1, 1'b0);
        for (int i = 1; i < len; i++) send_item(cont_byte(), 1'b1, 1'b0);
        sent += len;
      end else if (kind < 72) begin
        send_item(BYTE_NEWLINE, 1'b1, 1'b0);
        sent++;
      end else if (kind < 78) begin
        send_item(8'($urandom_range(255)), 1'b1, 1'b0);
        sent++;
      end else if (kind < 83) begin
        len = $urandom_range(2, 4);
        lead = (len == 2) ? 8'hDF : (len == 3) ? 8'hEF : 8'hF7;
        cut = $urandom_range(0, len - 2);
        send_item(lead & 8'($urandom_range(255) | 'hF0), 1'b1, 1'b0);
        for (int i = 0; i < cut; i++) send_item(cont_byte(), 1'b1, 1'b0);
        sent += cut + 1;
        if ($urandom_range(1) == 1) begin
          send_item(8'($urandom_range(255)), 1'b0, 1'b1);
          sent++;
        end
      end else if (kind < 86) begin
        send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      end else if (kind < 89) begin
        if ($urandom_range(1) == 1) begin
          send_item(8'($urandom_range(255)), 1'b1, 1'b1);
        end else begin
          send_item(8'($urandom_range(255)), 1'b0, 1'b1);
        end
        sent++;
      end else begin
        send_item(8'($urandom_range('h7F)), 1'b1, 1'b0);
        sent++;
      end
    end
  endtask

  task automatic run_random_phase(input int dw, input int nw, input int ww, input int pct);
    set_widths(dw, nw, ww);
    idle_pct = pct;
    random_text(160);
    settle();
    random_text(165);
    send_item(8'h00, 1'b0, 1'b1);
    settle();
  endtask

  task automatic test_random_texts();
    run_random_phase(16, 1, 1, 30);
    run_random_phase(1024, 64, 64, 0);
    run_random_phase(16, 64, 64, 60);
    run_random_phase(1024, 1, 1, 30);
    run_random_phase($urandom_range(16, 1024), $urandom_range(1, 64), $urandom_range(1, 64), 30);
    run_random_phase(int'(DISPLAY_WIDTH_RST), int'(NARROW_WIDTH_RST), int'(WIDE_WIDTH_RST), 15);
  endtask

  task automatic log_mismatch(input string what, input res_t want, input res_t got);
    errors++;
    if (reported < 10) begin
      reported++;
      $display("%s: expected start %0d end %0d cause %0d final %0b long %0b,",
               what, want.line_head, want.line_end, want.break_cause, want.final_line,
               want.too_long);
      $display("  got start %0d end %0d cause %0d final %0b long %0b",
               got.line_head, got.line_end, got.break_cause, got.final_line,
               got.too_long);
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct / 3) begin
      hold_left = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_line = {out_ch.line_head, out_ch.line_end, out_ch.break_cause, out_ch.final_line,
                  out_ch.too_long};
      if (expected_lines.size() == 0) begin
        log_mismatch("unexpected line", '0, got_line);
      end else begin
        want_line = expected_lines.pop_front();
        if (got_line.line_head !== want_line.line_head ||
            got_line.line_end !== want_line.line_end ||
            got_line.break_cause !== want_line.break_cause ||
            got_line.final_line !== want_line.final_line ||
            got_line.too_long !== want_line.too_long) begin
          log_mismatch("line mismatch", want_line, got_line);
        end
      end
    end
  end

  initial begin
    disp_w = int'(DISPLAY_WIDTH_RST);
    narrow_w = int'(NARROW_WIDTH_RST);
    wide_w = int'(WIDE_WIDTH_RST);
    clear_text();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    test_empty_text();
    test_utf8_decoding();
    test_wrap_rules();
    test_offset_saturation();
    test_random_texts();

    settle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
